@@ design/xft_pkg.sv @@
// ============================================================================
// XOR Fenwick tree package
// Shared widths, field codes and parameter defaults for the XOR Fenwick tree.
// ============================================================================
package xft_pkg;

   // Field widths of the request and response items.
   localparam int SIZE_W  = 11;
   localparam int POS_W   = 11;
   localparam int VALUE_W = 32;

   // Walk index width: one bit above a position so that an upward step past
   // the largest size still fits.
   localparam int WALK_W = POS_W + 1;

   // Stream data widths, packed fields padded to whole bytes.
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;

   // Request kinds carried in tuser.
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // Size register value after reset.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // Parameter defaults.
   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

endpackage

@@ design/xor_fenwick_tree.sv @@
// ============================================================================
// XOR Fenwick tree
// Binary indexed tree over XOR with point updates and range queries.
// ============================================================================
// Usage:
//   The req_ channel carries one item per transfer: tuser selects a point
//   update (XOR value into position) or a range query (positions position
//   through right_end). Updates produce nothing; each query produces one
//   rsp_ transfer holding the XOR of that range.
//   csr_wr_en writes size_in_use; update walks stop above it. Write it only
//   while the block is idle.
// Operation:
//   One item is worked at a time; req_tready is high only between items.
//   The node store is one RAM with a registered read, and the nodes on a
//   lowbit path are read one after another. An update reads each node on
//   its upward path and writes it back XORed with the value; a query reads
//   the nodes of both downward paths that lie in the store.
// Reset:
//   Reset starts a clearing pass that zeroes the store, one node per cycle,
//   over all DEPTH nodes (1024 by default); no request is taken during it.
// Stalls:
//   The result sits in an output register; the next request is accepted
//   while it waits. A query that finishes while the register is still full
//   holds until rsp_tready frees it.
// ============================================================================
module xor_fenwick_tree #(
   parameter int DEPTH      = xft_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = xft_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: position [10:0], right_end [21:11], value [53:22], zero pad
   input  logic [xft_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: kind [0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: range_xor [31:0]
   output logic [xft_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [xft_pkg::SIZE_W-1:0]       csr_wr_data
);

   import xft_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic [SIZE_W-1:0]     size_ff;
   logic [POS_W-1:0]      req_position;
   logic [POS_W-1:0]      req_right_end;
   logic [VALUE_W-1:0]    req_value;
   logic [VALUE_W-1:0]    rsp_range_xor;
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   // Size register, written by the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // Unpack the request fields.
   assign req_position  = req_tdata[POS_W-1:0];
   assign req_right_end = req_tdata[2*POS_W-1:POS_W];
   assign req_value     = req_tdata[2*POS_W+VALUE_W-1:2*POS_W];
   assign rsp_tdata     = RSP_TDATA_W'(rsp_range_xor);

   xft_engine #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_kind      (req_tuser),
      .req_position  (req_position),
      .req_right_end (req_right_end),
      .req_value     (req_value),
      .size_in_use   (size_ff),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_range_xor (rsp_range_xor),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   xft_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ design/xft_ram.sv @@
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module xft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/xft_engine.sv @@
// ============================================================================
// XOR Fenwick tree walk engine
// Sequences the clearing pass, the upward update walk (read, XOR, write back)
// and the two downward query walks over the node memory, and holds the
// result register.
// ============================================================================
module xft_engine #(
   parameter int DEPTH      = xft_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = xft_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_kind,
   input  logic [xft_pkg::POS_W-1:0]  req_position,
   input  logic [xft_pkg::POS_W-1:0]  req_right_end,
   input  logic [xft_pkg::VALUE_W-1:0] req_value,
   input  logic [xft_pkg::SIZE_W-1:0] size_in_use,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [xft_pkg::VALUE_W-1:0] rsp_range_xor,
   output logic                       mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
   output logic [DATA_WIDTH-1:0]      mem_wr_data,
   output logic                       mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]      mem_rd_data
);

   import xft_pkg::*;

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int DEPTH_W = $clog2(DEPTH + 1);
   localparam int CMP_W   = (WALK_W > DEPTH_W) ? WALK_W : DEPTH_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_UPD   = 2'd2;
   localparam logic [1:0] ST_QRY   = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [WALK_W-1:0]     walk_ff, walk_in;
   logic                  phase_ff, phase_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic                  query_ff;
   logic                  pend_ff;
   logic [ADDR_W-1:0]     pend_addr_ff;
   logic [DATA_WIDTH-1:0] acc_ff, acc_next;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_data_ff;

   logic                  accept;
   logic                  issue;
   logic                  rsp_load;
   logic [WALK_W-1:0]     low_bit;
   logic [WALK_W-1:0]     node_num_m1;
   logic [ADDR_W-1:0]     node_addr;
   logic                  walk_live;
   logic                  in_store;
   logic                  in_size;
   logic                  out_free;

   // Lowbit of the current node and its memory address (node n lives at n-1).
   assign low_bit     = walk_ff & (~walk_ff + WALK_W'(1));
   assign node_num_m1 = walk_ff - WALK_W'(1);
   assign node_addr   = ADDR_W'(node_num_m1);
   assign walk_live   = (walk_ff != '0);
   assign in_store    = (CMP_W'(walk_ff) <= CMP_W'(DEPTH));
   assign in_size     = (walk_ff <= WALK_W'(size_in_use));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Query accumulator takes the read data that lands this cycle.
   assign acc_next = (pend_ff && query_ff) ? (acc_ff ^ mem_rd_data) : acc_ff;

   // Sequencer for clearing, update walks and query walks.
   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      phase_in = phase_ff;
      clr_in   = clr_ff;
      issue    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               phase_in = 1'b0;
               if (req_kind == KIND_QUERY) begin
                  walk_in  = WALK_W'(req_right_end);
                  state_in = ST_QRY;
               end else begin
                  walk_in  = WALK_W'(req_position);
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            if (walk_live && in_size && in_store) begin
               issue   = 1'b1;
               walk_in = walk_ff + low_bit;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QRY: begin
            if (walk_live) begin
               issue   = in_store;
               walk_in = walk_ff - low_bit;
            end else if (!phase_ff) begin
               // Second walk covers prefix(position - 1); prefix(0) is empty.
               phase_in = 1'b1;
               walk_in  = (pos_ff == '0) ? '0 : (WALK_W'(pos_ff) - WALK_W'(1));
            end else if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Result register: loaded when a query ends, cleared on a transfer.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and payload registers.
   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      phase_ff     <= phase_in;
      pend_addr_ff <= node_addr;
      if (accept) begin
         pos_ff   <= req_position;
         value_ff <= DATA_WIDTH'(req_value);
         query_ff <= (req_kind == KIND_QUERY);
         acc_ff   <= '0;
      end else begin
         acc_ff <= acc_next;
      end
      if (rsp_load) begin
         rsp_data_ff <= VALUE_W'(acc_next);
      end
   end

   // Memory ports: the clearing pass owns the write port until it is done.
   assign mem_rd_en   = issue;
   assign mem_rd_addr = node_addr;
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = pend_ff && !query_ff;
         mem_wr_addr = pend_addr_ff;
         mem_wr_data = mem_rd_data ^ value_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_xor = rsp_data_ff;

   // A read never outlives the item that issued it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("pending node read while idle");

   // The write-back never hits the node being read in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
      else $error("read and write-back collide on one node");

   // A new result only appears at the end of a query walk.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_QRY))
      else $error("result raised outside a query");

   // No result is offered while the store is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result valid during clearing pass");

endmodule

@@ tb/tb_xor_fenwick_tree.sv @@
// ----------------------------------------------------------------------------
// Testbench for the XOR Fenwick tree
// Streams point XOR updates and range XOR queries into the block under several
// sizes in use, keeps its own copy of the node store to work out each range
// result, and checks every response transfer in order against that copy.
// ----------------------------------------------------------------------------
module tb_xor_fenwick_tree;
   timeunit 1ns;
   timeprecision 1ps;

   import xft_pkg::*;

   localparam int NODE_COUNT  = DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 250;

   typedef struct packed {
      logic               kind;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   right_end;
      logic [VALUE_W-1:0] value;
   } fenwick_req_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata   = '0;
   logic                    req_tuser   = KIND_UPDATE;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_wr_en   = 1'b0;
   logic [SIZE_W-1:0]       csr_wr_data = '0;

   // Shadow of the node store and the size register.
   logic [VALUE_W-1:0] tree_copy [1:NODE_COUNT];
   int unsigned        size_copy = SIZE_RESET;

   fenwick_req_type    pending_req [$];
   logic [VALUE_W-1:0] range_xor_due [$];

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   int unsigned send_gap       = 0;
   int unsigned rsp_stall      = 0;
   bit          send_burst     = 1'b0;
   bit          rsp_burst      = 1'b0;

   xor_fenwick_tree dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Walk the upward lowbit path, stopping above the size in use.
   function automatic void apply_point_xor(int unsigned pos, logic [VALUE_W-1:0] val);
      int unsigned lim;
      int unsigned p;
      lim = (size_copy > NODE_COUNT) ? NODE_COUNT : size_copy;
      p = pos;
      if (p == 0) return;
      while (p <= lim) begin
         tree_copy[p] ^= val;
         p += p & (~p + 1);
      end
   endfunction

   // Walk the downward lowbit path; nodes above the store read as zero.
   function automatic logic [VALUE_W-1:0] prefix_xor_of(int unsigned idx);
      logic [VALUE_W-1:0] acc;
      int unsigned i;
      acc = '0;
      i = idx;
      while (i > 0) begin
         if (i <= NODE_COUNT) acc ^= tree_copy[i];
         i -= i & (~i + 1);
      end
      return acc;
   endfunction

   function automatic fenwick_req_type make_req(logic kind, int unsigned pos,
                                                int unsigned rend,
                                                logic [VALUE_W-1:0] val);
      fenwick_req_type r;
      r.kind      = kind;
      r.position  = pos[POS_W-1:0];
      r.right_end = rend[POS_W-1:0];
      r.value     = val;
      return r;
   endfunction

   // Append one item to the tail of the pending queue.
   function automatic void enqueue_req(fenwick_req_type r);
      pending_req.insert(pending_req.size(), r);
   endfunction

   // Mostly positions inside the size in use, with some anywhere and some extremes.
   function automatic int unsigned pick_position(int unsigned lim);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 8) return $urandom_range(1, lim);
      if (r == 8) return $urandom_range(0, 2047);
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 1;
         2: return lim;
         3: return NODE_COUNT;
         default: return 2047;
      endcase
   endfunction

   function automatic fenwick_req_type random_req(int unsigned lim);
      int unsigned a;
      int unsigned b;
      logic [VALUE_W-1:0] val;
      case ($urandom_range(0, 19))
         0: val = '0;
         1, 2: val = '1;
         default: val = $urandom;
      endcase
      if ($urandom_range(0, 1) == 0)
         return make_req(KIND_UPDATE, pick_position(lim), $urandom_range(0, 2047), val);
      if ($urandom_range(0, 9) < 7) begin
         a = $urandom_range(1, lim);
         b = $urandom_range(1, lim);
         if (a > b) return make_req(KIND_QUERY, b, a, val);
         return make_req(KIND_QUERY, a, b, val);
      end
      return make_req(KIND_QUERY, pick_position(lim), pick_position(lim), val);
   endfunction

   task automatic write_size(input int unsigned v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[SIZE_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      size_copy = v;
   endtask

   // Wait until every item has been sent, the block is idle again and every
   // result has come back. Sampling on the falling edge keeps the check clear
   // of the driver's and monitor's updates at the rising edge.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_req.size() != 0 || req_tvalid || !req_tready || rsp_tvalid ||
             range_xor_due.size() != 0);
   endtask

   // Request driver: one transfer per item, random gap after each item.
   always @(posedge clock) begin : req_driver
      logic            next_valid;
      fenwick_req_type item;
      int unsigned     pos;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pos = req_tdata[POS_W-1:0];
            if (req_tuser == KIND_UPDATE) begin
               apply_point_xor(pos, req_tdata[2*POS_W +: VALUE_W]);
            end else begin
               range_xor_due.insert(range_xor_due.size(),
                                    prefix_xor_of(req_tdata[POS_W +: POS_W]) ^
                                    ((pos == 0) ? '0 : prefix_xor_of(pos - 1)));
            end
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_req.size() != 0) begin
               item = pending_req.pop_front();
               req_tdata <= {{(REQ_TDATA_W-2*POS_W-VALUE_W){1'b0}},
                             item.value, item.right_end, item.position};
               req_tuser <= item.kind;
               next_valid = 1'b1;
               if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 16);
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // Response monitor: checks each transfer and stalls at random afterwards.
   always @(posedge clock) begin : rsp_monitor
      logic [VALUE_W-1:0] expected;
      if (reset) begin
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (range_xor_due.size() == 0) begin
               $display("%0t: unexpected range result, actual %h", $realtime, rsp_tdata);
               mismatch_count++;
            end else begin
               expected = range_xor_due.pop_front();
               if (rsp_tdata[VALUE_W-1:0] !== expected) begin
                  $display("%0t: range_xor mismatch, expected %h actual %h",
                           $realtime, expected, rsp_tdata[VALUE_W-1:0]);
                  mismatch_count++;
               end
            end
            if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 16);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
      end
      rsp_tready <= !reset && (rsp_stall == 0);
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned phase_sizes [6];
      int unsigned lim;
      foreach (tree_copy[i]) tree_copy[i] = '0;
      phase_sizes = '{1, 2047, 0, 37, NODE_COUNT, $urandom_range(2, 1023)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_size(SIZE_RESET);

      // Directed items: store extremes, ignored and out-of-range updates,
      // empty and reversed ranges, ends beyond the store.
      enqueue_req(make_req(KIND_UPDATE, 1, 0, 32'hFFFF_FFFF));
      enqueue_req(make_req(KIND_UPDATE, NODE_COUNT, 0, 32'h0000_0001));
      enqueue_req(make_req(KIND_UPDATE, 0, 0, 32'hDEAD_BEEF));
      enqueue_req(make_req(KIND_UPDATE, 2047, 2047, 32'h1234_5678));
      enqueue_req(make_req(KIND_UPDATE, 1025, 0, 32'hAAAA_AAAA));
      enqueue_req(make_req(KIND_UPDATE, 683, 2047, 32'h5555_5555));
      enqueue_req(make_req(KIND_QUERY, 1, NODE_COUNT, 32'h0));
      enqueue_req(make_req(KIND_QUERY, 0, 0, 32'hFFFF_FFFF));
      enqueue_req(make_req(KIND_QUERY, 0, 2047, 32'h0));
      enqueue_req(make_req(KIND_QUERY, NODE_COUNT, NODE_COUNT, 32'h0));
      enqueue_req(make_req(KIND_QUERY, 2047, 2047, 32'h0));
      enqueue_req(make_req(KIND_QUERY, 9, 3, 32'h0));
      enqueue_req(make_req(KIND_QUERY, 1, 1, 32'h0));
      enqueue_req(make_req(KIND_QUERY, 683, 683, 32'h0));
      enqueue_req(make_req(KIND_UPDATE, 512, 0, 32'h0));
      enqueue_req(make_req(KIND_QUERY, 2, 1023, 32'h0));
      enqueue_req(make_req(KIND_QUERY, 1025, 2046, 32'h0));
      enqueue_req(make_req(KIND_UPDATE, 1023, 0, 32'h8000_0001));
      enqueue_req(make_req(KIND_QUERY, 1, 1023, 32'h0));
      wait_idle();

      // Random phases under a range of sizes; lowering the size leaves the
      // upper nodes populated, and queries still read them.
      foreach (phase_sizes[ph]) begin
         write_size(phase_sizes[ph]);
         lim = (phase_sizes[ph] > NODE_COUNT) ? NODE_COUNT : phase_sizes[ph];
         if (lim == 0) lim = 1;
         repeat (ITEMS_PER_PHASE) enqueue_req(random_req(lim));
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
design/xft_pkg.sv
design/xft_ram.sv
design/xft_engine.sv
design/xor_fenwick_tree.sv
tb/tb_xor_fenwick_tree.sv
